[src/bandlimited_wavetable_generator_unit_assert.svh]
// Assertion macros shared by the checker.
// No dependencies.
`ifndef BANDLIMITED_WAVETABLE_GENERATOR_UNIT_ASSERT_SVH
`define BANDLIMITED_WAVETABLE_GENERATOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BWG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwg check failed");
// next-cycle implication
`define BWG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwg check failed");
`endif

[src/bwg_pkg.sv]
// Package for the band-limited wavetable generator: constants, types, ROM.
// No dependencies.
package bwg_pkg;
    localparam int TABLE_LENGTH_DEF = 256;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int NUM_WAVES        = 4;
    localparam int ACC_W            = 40;

    localparam logic [2:0] KIND_SINE = 3'd0;
    localparam logic [2:0] KIND_TRI  = 3'd1;
    localparam logic [2:0] KIND_SQR  = 3'd2;
    localparam logic [2:0] KIND_SAW  = 3'd3;

    function automatic logic [15:0] quarter_sine(input logic [6:0] i);
        logic [15:0] t [0:64];
        t = '{16'd0, 16'd804, 16'd1608, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
              16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039,
              16'd11793, 16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151,
              16'd16846, 16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787,
              16'd21403, 16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811,
              16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683, 16'd28105,
              16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273, 16'd30571,
              16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971, 16'd32137,
              16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
              16'd32767};
        return (i > 7'd64) ? 16'd0 : t[i];
    endfunction

    // signed sine sample, phase in 1/256 turn
    function automatic logic signed [16:0] sine_at(input logic [7:0] p);
        logic [15:0] v;
        v = p[6] ? quarter_sine(7'd64 - {1'b0, p[5:0]}) : quarter_sine({1'b0, p[5:0]});
        return p[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic [4:0] wave_count(input logic [1:0] k);
        case (k)
            2'd0: return 5'd1;
            2'd1: return 5'd13;
            2'd2: return 5'd7;
            default: return 5'd26;
        endcase
    endfunction

    // rounded 32768/h
    function automatic logic [16:0] inv_weight(input logic [5:0] h);
        case (h)
            6'd1:  return 17'd32768;
            6'd2:  return 17'd16384;
            6'd3:  return 17'd10923;
            6'd4:  return 17'd8192;
            6'd5:  return 17'd6554;
            6'd6:  return 17'd5461;
            6'd7:  return 17'd4681;
            6'd8:  return 17'd4096;
            6'd9:  return 17'd3641;
            6'd10: return 17'd3277;
            6'd11: return 17'd2979;
            6'd12: return 17'd2731;
            6'd13: return 17'd2521;
            6'd14: return 17'd2341;
            6'd15: return 17'd2185;
            6'd16: return 17'd2048;
            6'd17: return 17'd1928;
            6'd18: return 17'd1820;
            6'd19: return 17'd1725;
            6'd20: return 17'd1638;
            6'd21: return 17'd1560;
            6'd22: return 17'd1489;
            6'd23: return 17'd1425;
            6'd24: return 17'd1365;
            6'd25: return 17'd1311;
            6'd26: return 17'd1260;
            default: return 17'd0;
        endcase
    endfunction

    // rounded 32768/h^2, odd h
    function automatic logic [16:0] inv_sq_weight(input logic [5:0] h);
        case (h)
            6'd1:  return 17'd32768;
            6'd3:  return 17'd3641;
            6'd5:  return 17'd1311;
            6'd7:  return 17'd669;
            6'd9:  return 17'd405;
            6'd11: return 17'd271;
            6'd13: return 17'd194;
            6'd15: return 17'd146;
            6'd17: return 17'd113;
            6'd19: return 17'd91;
            6'd21: return 17'd74;
            6'd23: return 17'd62;
            6'd25: return 17'd52;
            default: return 17'd0;
        endcase
    endfunction

    // weight of harmonic k (1-based) for wave kind, signed
    function automatic logic signed [16:0] wave_weight(input logic [1:0] kd,
                                                       input logic [4:0] k);
        logic [5:0]  h;
        logic [16:0] w;
        h = (kd == 2'd1 || kd == 2'd2) ? ({k, 1'b0} - 6'd1) : {1'b0, k};
        w = (kd == 2'd1) ? inv_sq_weight(h) : inv_weight(h);
        if ((kd == 2'd1 || kd == 2'd3) && k[0])
            return -$signed(w);
        return $signed(w);
    endfunction

    function automatic logic [5:0] wave_harm(input logic [1:0] kd, input logic [4:0] k);
        return (kd == 2'd1 || kd == 2'd2) ? ({k, 1'b0} - 6'd1) : {1'b0, k};
    endfunction

    typedef struct packed {
        logic       start;
        logic [1:0] kind;
    } bwg_build_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bwg_build_stat_t;
endpackage

[src/bwg_divider.sv]
// Restoring divider, one quotient bit per cycle: (num + den/2) / den.
// Depends on bwg_pkg.
module bwg_divider
    import bwg_pkg::*;
#(
    parameter int NUM_W = 56,
    parameter int DEN_W = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next, done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next   = num + NUM_W'(den >> 1);
            r_next   = '0;
            cnt_next = CW'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
                r_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

[src/bwg_builder.sv]
// Table builder: harmonic accumulation in a sum RAM, peak scan, normalisation.
// Depends on bwg_pkg and bwg_divider. Writes into the wave store port.
module bwg_builder
    import bwg_pkg::*;
#(
    parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bwg_build_req_t                  req,
    output bwg_build_stat_t                 stat,
    output logic                            wr_en,
    output logic [$clog2(TABLE_LENGTH)-1:0] wr_addr,
    output logic signed [SAMPLE_BITS-1:0]   wr_data
);
    localparam int AW    = $clog2(TABLE_LENGTH);
    localparam int NUM_W = ACC_W + SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] PEAK = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ACC   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_NORM  = 5'b01000,
        S_DIV   = 5'b10000
    } bstate_t;

    bstate_t          st_reg, st_next;
    logic [1:0]       kind_reg;
    logic [4:0]       k_reg, k_next;
    logic [AW:0]      j_reg, j_next;
    logic [AW-1:0]    m_reg, m_next;
    logic             first_reg, first_next;
    logic [ACC_W-1:0] peak_reg, peak_next;
    logic             done_reg;

    logic signed [ACC_W-1:0] sums [0:TABLE_LENGTH-1];
    logic signed [ACC_W-1:0] rd_reg;
    logic signed [ACC_W-1:0] rq_reg;
    logic [AW-1:0]           rd_addr;
    logic                    sw_en_reg;
    logic [AW-1:0]           sw_addr_reg;
    logic signed [ACC_W-1:0] sw_data_reg;
    logic                    pv_reg;
    logic [AW-1:0]           pa_reg;
    logic signed [16:0]      ps_reg;
    logic                    pfirst_reg;
    logic signed [16:0]      w_reg;
    logic signed [33:0]      prod_reg;
    logic                    qv_reg;
    logic [AW-1:0]           qa_reg;
    logic                    qfirst_reg;
    logic [7:0]              phase;
    logic                    acc_issue;
    logic                    div_start;
    logic                    div_done;
    logic [NUM_W-1:0]        quot;
    logic [ACC_W-1:0]        absr;
    logic                    neg_reg;
    logic [AW-1:0]           na_reg;
    logic                    zpeak;

    assign phase = (AW >= 8) ? 8'(m_reg >> (AW - 8)) : 8'({m_reg, 8'd0} >> AW);
    assign rd_addr = j_reg[AW-1:0];
    assign acc_issue = (st_reg == S_ACC) && !j_reg[AW];
    assign absr = rd_reg[ACC_W-1] ? ACC_W'(-rd_reg) : ACC_W'(rd_reg);
    assign zpeak = (peak_reg == '0);

    always_comb
    begin
        st_next    = st_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        first_next = first_reg;
        peak_next  = peak_reg;
        div_start  = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    st_next    = S_ACC;
                    k_next     = 5'd1;
                    j_next     = '0;
                    m_next     = '0;
                    first_next = 1'b1;
                end
            end
            S_ACC:
            begin
                if (!j_reg[AW])
                begin
                    j_next = j_reg + 1'b1;
                    m_next = m_reg + AW'(wave_harm(kind_reg, k_reg));
                end
                else if (!pv_reg && !qv_reg && !sw_en_reg)
                begin
                    j_next = '0;
                    m_next = '0;
                    first_next = 1'b0;
                    if (k_reg == wave_count(kind_reg))
                    begin
                        st_next   = S_SCAN;
                        peak_next = '0;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (pv_reg && absr > peak_reg)
                    peak_next = absr;
                if (!j_reg[AW])
                    j_next = j_reg + 1'b1;
                else if (!pv_reg)
                begin
                    st_next = S_NORM;
                    j_next  = '0;
                end
            end
            S_NORM:
            begin
                if (j_reg[AW])
                    st_next = S_IDLE;
                else if (pv_reg)
                begin
                    st_next   = S_DIV;
                    div_start = !zpeak;
                end
            end
            S_DIV:
            begin
                if (zpeak || div_done)
                begin
                    st_next = S_NORM;
                    j_next  = j_reg + 1'b1;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // sum RAM: one read, one write port; the read of entry j in pass k never
    // meets its own pending write, as each entry is touched once per pass
    always_ff @(posedge clk)
    begin
        if (sw_en_reg)
            sums[sw_addr_reg] <= sw_data_reg;
        rd_reg <= sums[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            pv_reg    <= 1'b0;
            qv_reg    <= 1'b0;
            sw_en_reg <= 1'b0;
            done_reg  <= 1'b0;
            peak_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            peak_reg  <= peak_next;
            pv_reg    <= acc_issue || (st_reg == S_SCAN && !j_reg[AW])
                         || (st_reg == S_NORM && !j_reg[AW] && !pv_reg);
            qv_reg    <= pv_reg && st_reg == S_ACC;
            sw_en_reg <= qv_reg;
            done_reg  <= (st_reg == S_NORM) && j_reg[AW];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        first_reg  <= first_next;
        if (req.start && st_reg == S_IDLE)
            kind_reg <= req.kind;
        pa_reg      <= rd_addr;
        ps_reg      <= sine_at(phase);
        pfirst_reg  <= first_reg;
        w_reg       <= wave_weight(kind_reg, k_reg);
        prod_reg    <= w_reg * ps_reg;
        rq_reg      <= rd_reg;
        qa_reg      <= pa_reg;
        qfirst_reg  <= pfirst_reg;
        sw_addr_reg <= qa_reg;
        sw_data_reg <= (qfirst_reg ? ACC_W'(0) : rq_reg) + ACC_W'(prod_reg);
        if (div_start || (st_reg == S_NORM && pv_reg))
        begin
            neg_reg <= rd_reg[ACC_W-1];
            na_reg  <= j_reg[AW-1:0];
        end
    end

    bwg_divider #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(absr) * NUM_W'(PEAK)),
        .den   (peak_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign wr_en   = (st_reg == S_DIV) && (zpeak || div_done);
    assign wr_addr = na_reg;
    assign wr_data = zpeak ? '0 :
                     (neg_reg ? -$signed(SAMPLE_BITS'(quot)) : $signed(SAMPLE_BITS'(quot)));
    assign stat.busy = (st_reg != S_IDLE);
    assign stat.done = done_reg;
endmodule

[src/bandlimited_wavetable_generator_unit.sv]
// Top level of the band-limited wavetable generator: request handling and wave store.
// Depends on bwg_pkg and bwg_builder.
//
//  channel | signals                     | direction
//  input   | in_valid in_stall kind index| in
//  output  | out_valid out_stall sample  | out
//
// A request for a built wave: the sample passes the store read register, then the output
// register; the input stalls until the output register has taken the sample.
// First request for a wave stalls for the build: sum RAM passes, a peak scan, then
// a bit-serial division for each entry.
// Reset clears the state, the output valid and the built flags; stores hold no valid state.
// The output register holds a beat while out_stall is high.
module bandlimited_wavetable_generator_unit
    import bwg_pkg::*;
#(
    parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample
);
    localparam int AW = $clog2(TABLE_LENGTH);

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_BUILD = 4'b0010,
        T_READ  = 4'b0100,
        T_OUT   = 4'b1000
    } tstate_t;

    tstate_t               st_reg, st_next;
    logic [NUM_WAVES-1:0]  built_reg;
    logic [2:0]            kind_reg;
    logic [AW-1:0]         idx_reg;
    logic signed [SAMPLE_BITS-1:0] store [0:NUM_WAVES*TABLE_LENGTH-1];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic signed [15:0]    sample_reg;
    logic                  ovalid_reg;
    bwg_build_req_t        breq;
    bwg_build_stat_t       bstat;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic                  take;
    logic [AW-1:0]         idx_in;

    assign idx_in   = AW'(index % TABLE_LENGTH);
    assign in_stall = (st_reg != T_IDLE);
    assign take     = in_valid && !in_stall;
    assign breq.start = (st_reg == T_IDLE) && take && (kind < 3'(NUM_WAVES))
                        && !built_reg[kind[1:0]];
    assign breq.kind  = kind[1:0];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            T_IDLE:  if (take) st_next = breq.start ? T_BUILD : T_READ;
            T_BUILD: if (bstat.done) st_next = T_READ;
            T_READ:  st_next = T_OUT;
            T_OUT:   if (!ovalid_reg || !out_stall) st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[{kind_reg[1:0], wr_addr}] <= wr_data;
        rd_reg <= store[{kind_reg[1:0], idx_reg}];
        if (take)
        begin
            kind_reg <= kind;
            idx_reg  <= idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= T_IDLE;
            built_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (bstat.done)
                built_reg[kind_reg[1:0]] <= 1'b1;
            if (st_reg == T_OUT && (!ovalid_reg || !out_stall))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == T_OUT && (!ovalid_reg || !out_stall))
            sample_reg <= (kind_reg < 3'(NUM_WAVES)) ? 16'(rd_reg) : 16'sd0;
    end

    bwg_builder #(.TABLE_LENGTH(TABLE_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (breq),
        .stat    (bstat),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign out_valid = ovalid_reg;
    assign sample    = sample_reg;
endmodule

[src/bwg_checker.sv]
// Port-level checker for the wavetable generator, bound to the top level.
// Depends on the assertion macro header.
`include "bandlimited_wavetable_generator_unit_assert.svh"
module bwg_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample
);
    `BWG_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(sample))
    `BWG_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    `BWG_ASSERT_IMP(a_peak, out_valid, sample != -16'sd32768)
endmodule

bind bandlimited_wavetable_generator_unit bwg_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

[test/tb_bandlimited_wavetable_generator_unit.sv]
// Testbench for bandlimited_wavetable_generator_unit: directed table then random beats,
// each sample checked against a fixed-point harmonic-sum table builder.
// Depends on bwg_pkg and the RTL of the unit.
module tb_bandlimited_wavetable_generator_unit;
    import bwg_pkg::*;

    localparam int TLEN = 256;
    localparam int N_RANDOM = 1600;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [2:0] KIND_NONE = 3'd4;
    localparam logic [2:0] KIND_TOP = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  index;
        logic        known;
        logic [15:0] value;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] kind;
    logic [7:0] index;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] sample;

    bandlimited_wavetable_generator_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .index(index), .out_valid(out_valid), .out_stall(out_stall),
        .sample(sample)
    );

    logic [15:0] waves [0:3][0:TLEN-1];
    logic [3:0]  waves_built;
    logic [15:0] expected_samples [$];
    int errors;
    int beats_in;
    int beats_out;
    int idle_cycles;
    bit hold_output;
    bit calm;

    stim_row_t rows [] = '{
        '{KIND_NONE, 8'd0,   1'b1, 16'd0},
        '{KIND_TOP,  8'd255, 1'b1, 16'd0},
        '{3'd5,      8'd85,  1'b1, 16'd0},
        '{3'd6,      8'd170, 1'b1, 16'd0},
        '{KIND_SINE, 8'd0,   1'b1, 16'd0},
        '{KIND_SINE, 8'd64,  1'b1, 16'd32767},
        '{KIND_SINE, 8'd128, 1'b1, 16'd0},
        '{KIND_SINE, 8'd192, 1'b1, 16'h8001},
        '{KIND_SINE, 8'd255, 1'b0, 16'd0},
        '{KIND_TRI,  8'd0,   1'b1, 16'd0},
        '{KIND_TRI,  8'd64,  1'b0, 16'd0},
        '{KIND_TRI,  8'd255, 1'b0, 16'd0},
        '{KIND_SQR,  8'd0,   1'b1, 16'd0},
        '{KIND_SQR,  8'd32,  1'b0, 16'd0},
        '{KIND_SQR,  8'd200, 1'b0, 16'd0},
        '{KIND_SAW,  8'd0,   1'b1, 16'd0},
        '{KIND_SAW,  8'd127, 1'b0, 16'd0},
        '{KIND_SAW,  8'd128, 1'b1, 16'd0},
        '{KIND_SAW,  8'd255, 1'b0, 16'd0},
        '{KIND_NONE, 8'd170, 1'b1, 16'd0}
    };

    function automatic logic signed [16:0] sine_lookup(input logic [7:0] p);
        logic [5:0] r;
        logic [16:0] v;
        r = p[5:0];
        v = {1'b0, quarter_sine(p[6] ? 7'd64 - {1'b0, r} : {1'b0, r})};
        return p[7] ? -$signed(v) : $signed(v);
    endfunction

    task automatic build_wave(input int wk);
        logic signed [39:0] sums [0:TLEN-1];
        logic [39:0] mag;
        logic [39:0] peak_mag;
        logic [63:0] q;
        int count;
        int h;
        int d;
        longint w;
        count = (wk == 0) ? 1 : (wk == 1) ? 13 : (wk == 2) ? 7 : 26;
        for (int j = 0; j < TLEN; j++)
            sums[j] = '0;
        for (int k = 1; k <= count; k++)
        begin
            h = (wk == 1 || wk == 2) ? 2 * k - 1 : k;
            d = (wk == 1) ? h * h : h;
            w = (32768 + d / 2) / d;
            if ((wk == 1 || wk == 3) && (k % 2 == 1))
                w = -w;
            for (int j = 0; j < TLEN; j++)
                sums[j] += 40'(w * longint'(sine_lookup(8'((h * j) % TLEN))));
        end
        peak_mag = '0;
        for (int j = 0; j < TLEN; j++)
        begin
            mag = sums[j] < 0 ? 40'(-sums[j]) : 40'(sums[j]);
            if (mag > peak_mag)
                peak_mag = mag;
        end
        for (int j = 0; j < TLEN; j++)
        begin
            waves[wk][j] = '0;
            if (peak_mag != 0)
            begin
                mag = sums[j] < 0 ? 40'(-sums[j]) : 40'(sums[j]);
                q = (64'(mag) * 64'd32767 + 64'(peak_mag >> 1)) / 64'(peak_mag);
                waves[wk][j] = sums[j] < 0 ? 16'(-q) : 16'(q);
            end
        end
        waves_built[wk] = 1'b1;
    endtask

    task automatic predict_sample(input logic [2:0] k, input logic [7:0] i,
                                  output logic [15:0] v);
        v = '0;
        if (k < 3'(NUM_WAVES))
        begin
            if (!waves_built[k[1:0]])
                build_wave(k[1:0]);
            v = waves[k[1:0]][i];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch: %s got %0d want %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    task automatic send_beat(input logic [2:0] k, input logic [7:0] i);
        logic [15:0] v;
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        index <= i;
        predict_sample(k, i, v);
        expected_samples.push_back(v);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_in++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_output = 1'b0;
            end
            out_stall <= (!calm && $urandom_range(99) < 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (expected_samples.size() == 0)
                report_mismatch("unexpected beat", sample, 16'd0);
            else if (sample !== expected_samples[0])
            begin
                report_mismatch("sample", sample, expected_samples[0]);
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb_bandlimited_wavetable_generator_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] k;
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        index = '0;
        errors = 0;
        beats_in = 0;
        waves_built = '0;
        hold_output = 1'b0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            send_beat(rows[r].kind, rows[r].index);
            if (rows[r].known && expected_samples[$] !== rows[r].value)
                report_mismatch($sformatf("table row %0d", r), expected_samples[$],
                                rows[r].value);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_output = 1'b1;
            calm = (n >= 700 && n < 1000);
            k = ($urandom_range(99) < 8) ? 3'($urandom_range(4, 7))
                                         : 3'($urandom_range(0, 3));
            send_beat(k, 8'($urandom));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_samples.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            $display("%0d samples never arrived", expected_samples.size());
            errors++;
        end

        $display("covered %0d requests, %0d samples, all four tables plus unknown kinds",
                 beats_in, beats_out);
        if (errors == 0)
            $display("tb_bandlimited_wavetable_generator_unit: done, clean");
        else
            $display("tb_bandlimited_wavetable_generator_unit: done, errors");
        $finish;
    end
endmodule
